// ===== hw/rtl/nlp_pkg.sv =====
package nlp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 24;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 17;

    // step_size * |error| shifted up by 19
    localparam int NUM_W = 51;
    // quotient magnitude stays below 2^42 because energy is at least epsilon
    localparam int Q_W   = 42;
    localparam int G_W   = Q_W + 1;

    // epsilon 1e-6 in Q.30
    localparam int EPS_Q30 = 1074;

    localparam logic [CFG_IW-1:0] REG_ORDER     = 2'd0;
    localparam logic [CFG_IW-1:0] REG_LOOKAHEAD = 2'd1;
    localparam logic [CFG_IW-1:0] REG_STEP      = 2'd2;
    localparam logic [CFG_IW-1:0] REG_DECAY     = 2'd3;

endpackage

// ===== hw/rtl/nlp_div.sv =====
module nlp_div import nlp_pkg::*; #(
    parameter int DEN_W = 38
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   quo_reg;

    logic [DEN_W:0]     shifted;
    logic               ge;
    logic [DEN_W-1:0]   rem_next;

    // one restoring step per cycle, msb first
    always_comb begin
        shifted  = {rem_reg, num_reg[NUM_W-1]};
        ge       = shifted >= {1'b0, den_reg};
        rem_next = ge ? DEN_W'(shifted - {1'b0, den_reg}) : DEN_W'(shifted);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg[Q_W-1:0];

endmodule

// ===== hw/rtl/nlms_leaky_predictor_unit.sv =====
// Leaky normalized LMS predictor for Q1.15 audio.
// Input channel s_valid/s_ready/s_sample takes one sample per item; the
// result channel m_valid/m_ready/m_prediction returns one Q1.15 prediction
// per item. cfg_we/cfg_index/cfg_data writes one of order_in_use, look_ahead,
// step_size and decay, as cfg_index selects; write only while the block is idle.
// Sample history, weights and prediction history live in three
// synchronous memories with registered reads.
// Per item: accept the sample, a dot product and energy pass over the n
// taps in use, the error, the serial divider, then a weight update pass.
// The prediction is registered at the end of the dot pass. The next item
// is taken once the update pass is done.
// After reset a clearing pass zeroes the memories; no item is taken
// during it, configuration writes are.
// A stalled receiver holds the prediction in the output register; the
// block works on and waits only if the next prediction is ready before
// the previous one was taken.
module nlms_leaky_predictor_unit import nlp_pkg::*; #(
    parameter int MAX_TAPS      = 32,
    parameter int MAX_LOOKAHEAD = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_prediction,
    input  logic                       cfg_we,
    input  logic [CFG_IW-1:0]          cfg_index,
    input  logic [CFG_DW-1:0]          cfg_data
);

    localparam int TIW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PIW   = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
    localparam int NW    = $clog2(MAX_TAPS + 1);
    localparam int AW    = 41 + $clog2(MAX_TAPS);
    localparam int EW    = 33 + $clog2(MAX_TAPS);
    localparam int CLR_N = (MAX_TAPS > MAX_LOOKAHEAD) ? MAX_TAPS : MAX_LOOKAHEAD;
    localparam int CW    = $clog2(CLR_N + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DOT  = 3'd2;
    localparam logic [2:0] S_PRD  = 3'd3;
    localparam logic [2:0] S_DST  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;

    localparam logic signed [AW-1:0] Y_MAX = AW'(32767);
    localparam logic signed [AW-1:0] Y_MIN = -AW'(32768);
    localparam logic signed [59:0]   W_MAX = 60'sd8388607;
    localparam logic signed [59:0]   W_MIN = -60'sd8388608;

    logic [2:0]  state_reg;
    logic [5:0]  order_reg;
    logic [5:0]  la_reg;
    logic [15:0] step_reg;
    logic [16:0] decay_reg;

    logic signed [SAMPLE_W-1:0] hmem [MAX_TAPS];
    logic signed [WEIGHT_W-1:0] wmem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] pmem [MAX_LOOKAHEAD];

    logic [TIW-1:0] hp_reg;
    logic [TIW-1:0] hp_next;
    logic [PIW-1:0] pp_reg;
    logic [PIW-1:0] pp_next;
    logic [CW-1:0]  clr_reg;

    logic [NW-1:0]  n_eff;
    logic [PIW-1:0] la_eff;

    logic [NW-1:0]  iss_reg;
    logic           iss;
    logic [TIW-1:0] h_raddr;
    logic [PIW-1:0] p_raddr;

    logic                       rv_reg;
    logic [TIW-1:0]             tap1_reg;
    logic signed [WEIGHT_W-1:0] w_q_reg;
    logic signed [SAMPLE_W-1:0] h_q_reg;
    logic signed [SAMPLE_W-1:0] p_q_reg;

    logic                 pv_reg;
    logic [TIW-1:0]       tap2_reg;
    logic signed [39:0]   wx_reg;
    logic signed [31:0]   xx_reg;
    logic signed [41:0]   leak_prod_reg;
    logic signed [58:0]   upd_prod_reg;

    logic signed [AW-1:0] acc_reg;
    logic [EW-1:0]        en_reg;
    logic signed [AW-1:0] acc_rnd;
    logic signed [AW-1:0] y_full;
    logic signed [SAMPLE_W-1:0] y;

    logic signed [41:0] leak_r;
    logic signed [58:0] upd_r;
    logic signed [59:0] w_sum;
    logic signed [WEIGHT_W-1:0] w_new;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [SAMPLE_W-1:0] m_pred_reg;
    logic                       m_valid_reg;
    logic                       err_neg_reg;
    logic [NUM_W-1:0]           mag_reg;
    logic signed [G_W-1:0]      g_reg;

    logic signed [16:0] err;
    logic [15:0]        err_abs;
    logic [31:0]        mag_prod;

    logic           accept;
    logic           pass_done;
    logic           out_free;
    logic           div_start;
    logic           div_done;
    logic [Q_W-1:0] div_quo;

    always_comb begin
        if (order_reg == 6'd0) begin
            n_eff = NW'(1);
        end else if (10'(order_reg) > 10'(MAX_TAPS)) begin
            n_eff = NW'(MAX_TAPS);
        end else begin
            n_eff = NW'(order_reg);
        end
        if (11'(la_reg) > 11'(MAX_LOOKAHEAD - 1)) begin
            la_eff = PIW'(MAX_LOOKAHEAD - 1);
        end else begin
            la_eff = PIW'(la_reg);
        end
    end

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign iss       = ((state_reg == S_DOT) || (state_reg == S_UPD)) && (iss_reg < n_eff);
    assign pass_done = (iss_reg == n_eff) && !rv_reg && !pv_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign div_start = (state_reg == S_DST);

    always_comb begin
        hp_next = (hp_reg == TIW'(MAX_TAPS - 1)) ? '0 : hp_reg + TIW'(1);
        pp_next = (pp_reg == PIW'(MAX_LOOKAHEAD - 1)) ? '0 : pp_reg + PIW'(1);
        // circular history, entry k back from the newest
        if (hp_reg >= iss_reg[TIW-1:0]) begin
            h_raddr = hp_reg - iss_reg[TIW-1:0];
        end else begin
            h_raddr = TIW'({1'b0, hp_reg} + (TIW+1)'(MAX_TAPS) - {1'b0, iss_reg[TIW-1:0]});
        end
        if (pp_next >= la_eff) begin
            p_raddr = pp_next - la_eff;
        end else begin
            p_raddr = PIW'({1'b0, pp_next} + (PIW+1)'(MAX_LOOKAHEAD) - {1'b0, la_eff});
        end
    end

    always_comb begin
        acc_rnd = acc_reg + AW'(1 << 19);
        y_full  = acc_rnd >>> 20;
        if (y_full > Y_MAX) begin
            y = 16'sh7fff;
        end else if (y_full < Y_MIN) begin
            y = -16'sh8000;
        end else begin
            y = SAMPLE_W'(y_full);
        end
    end

    always_comb begin
        leak_r = (leak_prod_reg + 42'sd32768) >>> 16;
        upd_r  = (upd_prod_reg + 59'sd16384) >>> 15;
        w_sum  = 60'(leak_r) + 60'(upd_r);
        if (w_sum > W_MAX) begin
            w_new = WEIGHT_W'(W_MAX);
        end else if (w_sum < W_MIN) begin
            w_new = WEIGHT_W'(W_MIN);
        end else begin
            w_new = WEIGHT_W'(w_sum);
        end
    end

    // look_ahead of zero compares with the prediction just made
    always_comb begin
        err      = 17'(x_reg) - ((la_eff == '0) ? 17'(y_reg) : 17'(p_q_reg));
        err_abs  = err[16] ? 16'(-err) : 16'(err);
        mag_prod = step_reg * err_abs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= 6'd8;
            la_reg    <= 6'd1;
            step_reg  <= 16'd655;
            decay_reg <= 17'd65536;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORDER:     order_reg <= cfg_data[5:0];
                REG_LOOKAHEAD: la_reg    <= cfg_data[5:0];
                REG_STEP:      step_reg  <= cfg_data[15:0];
                REG_DECAY:     decay_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            hp_reg      <= '0;
            pp_reg      <= '0;
            iss_reg     <= '0;
            rv_reg      <= 1'b0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rv_reg <= iss;
            pv_reg <= rv_reg;
            if (iss) begin
                iss_reg <= iss_reg + NW'(1);
            end
            if ((state_reg == S_DOT) && pass_done && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + CW'(1);
                    if (clr_reg == CW'(CLR_N - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        hp_reg    <= hp_next;
                        iss_reg   <= '0;
                        state_reg <= S_DOT;
                    end
                end
                S_DOT: begin
                    if (pass_done && out_free) begin
                        pp_reg    <= pp_next;
                        state_reg <= S_PRD;
                    end
                end
                S_PRD: state_reg <= S_DST;
                S_DST: state_reg <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        iss_reg   <= '0;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (pass_done) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= s_sample;
            acc_reg <= '0;
            en_reg  <= EW'(EPS_Q30);
        end else if ((state_reg == S_DOT) && pv_reg) begin
            acc_reg <= acc_reg + AW'(wx_reg);
            en_reg  <= en_reg + EW'(xx_reg[30:0]);
        end
        if ((state_reg == S_DOT) && pass_done && out_free) begin
            m_pred_reg <= y;
            y_reg      <= y;
        end
        if (state_reg == S_PRD) begin
            err_neg_reg <= err[16];
            mag_reg     <= {mag_prod, 19'd0};
        end
        if (div_done) begin
            g_reg <= err_neg_reg ? -G_W'({1'b0, div_quo}) : G_W'({1'b0, div_quo});
        end
    end

    // tap pipeline: read, multiply, accumulate or write back
    always_ff @(posedge aclk) begin
        tap1_reg      <= iss_reg[TIW-1:0];
        w_q_reg       <= wmem[iss_reg[TIW-1:0]];
        h_q_reg       <= hmem[h_raddr];
        p_q_reg       <= pmem[p_raddr];
        tap2_reg      <= tap1_reg;
        wx_reg        <= w_q_reg * h_q_reg;
        xx_reg        <= h_q_reg * h_q_reg;
        leak_prod_reg <= w_q_reg * $signed({1'b0, decay_reg});
        upd_prod_reg  <= g_reg * h_q_reg;
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_CLR) && (clr_reg < CW'(MAX_TAPS))) begin
            hmem[clr_reg[TIW-1:0]] <= '0;
        end else if (accept) begin
            hmem[hp_next] <= s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_CLR) && (clr_reg < CW'(MAX_TAPS))) begin
            wmem[clr_reg[TIW-1:0]] <= '0;
        end else if ((state_reg == S_UPD) && pv_reg) begin
            wmem[tap2_reg] <= w_new;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_CLR) && (clr_reg < CW'(MAX_LOOKAHEAD))) begin
            pmem[clr_reg[PIW-1:0]] <= '0;
        end else if ((state_reg == S_DOT) && pass_done && out_free) begin
            pmem[pp_next] <= y;
        end
    end

    nlp_div #(
        .DEN_W (EW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (mag_reg),
        .den     (en_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign m_valid      = m_valid_reg;
    assign m_prediction = m_pred_reg;

    a_wb_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_UPD) && pv_reg) |-> (NW'(tap2_reg) < n_eff))
        else $error("weight write back beyond taps in use");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_DOT))
        else $error("accepted item did not start the dot pass");

    a_out_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DOT) && pass_done && m_valid_reg && !m_ready)
        |=> (state_reg == S_DOT))
        else $error("prediction overwrote a pending item");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_pass_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == S_UPD) |-> $past(div_done))
        else $error("update pass started without a gain");

endmodule
